[hw/rtl/dtpc_pkg.sv]
`timescale 1ns / 1ps

package dtpc_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd1;
  localparam logic [2:0] REG_DEPTH_LIMIT     = 3'd2;
  localparam logic [2:0] REG_CENTER_X        = 3'd3;
  localparam logic [2:0] REG_CENTER_Y        = 3'd4;
  localparam logic [2:0] REG_INV_FOCAL_X     = 3'd5;
  localparam logic [2:0] REG_INV_FOCAL_Y     = 3'd6;
  localparam logic [2:0] REG_INV_DEPTH_SCALE = 3'd7;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Raster limits.
  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // Register reset values.
  localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [7:0]  RST_SAMPLE_INTERVAL = 8'd1;
  localparam logic [15:0] RST_DEPTH_LIMIT     = 16'd65535;
  localparam logic [15:0] RST_CENTER_X        = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y        = 16'd3840;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd32768;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd32768;
  localparam logic [31:0] RST_INV_DEPTH_SCALE = 32'd4294967;

  // Operand selections of the shared multiplier.
  localparam logic [2:0] MS_Z  = 3'd0;  // depth times depth scale
  localparam logic [2:0] MS_TX = 3'd1;  // column offset times z
  localparam logic [2:0] MS_AX = 3'd2;  // upper part of t times 1/fx
  localparam logic [2:0] MS_BX = 3'd3;  // lower part of t times 1/fx
  localparam logic [2:0] MS_TY = 3'd4;  // row offset times z
  localparam logic [2:0] MS_AY = 3'd5;  // upper part of t times 1/fy
  localparam logic [2:0] MS_BY = 3'd6;  // lower part of t times 1/fy

  typedef struct packed {
    logic [15:0] depth_raw;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        point_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] mul_sel;
    logic       ld_z;
    logic       ld_t;
    logic       ld_a;
    logic       ld_x;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic kept;
  } sts_t;

endpackage

[hw/rtl/dtpc_datapath.sv]
`timescale 1ns / 1ps

module dtpc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dtpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dtpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  dtpc_pkg::in_t                     in_data,
  input  dtpc_pkg::cmd_t                    cmd,
  output dtpc_pkg::sts_t                    sts,
  output dtpc_pkg::out_t                    out_data
);
  import dtpc_pkg::*;

  // Configuration registers.
  logic [12:0] image_width_r;
  logic [7:0]  sample_interval_r;
  logic [15:0] depth_limit_r;
  logic [15:0] center_x_r;
  logic [15:0] center_y_r;
  logic [23:0] inv_focal_x_r;
  logic [23:0] inv_focal_y_r;
  logic [31:0] inv_depth_scale_r;

  // Raster position.
  logic [11:0] col_r, row_r;
  logic [7:0]  cph_r, rph_r;
  logic [11:0] col_nxt, row_nxt;
  logic [7:0]  cph_nxt, rph_nxt;
  logic [11:0] col_cur, row_cur;
  logic [7:0]  cph_cur, rph_cur;
  logic [12:0] width_eff;
  logic [7:0]  interval_eff;
  logic [12:0] col_inc, row_inc;
  logic [8:0]  cph_inc, rph_inc;
  logic [15:0] pos_x, pos_y;

  // Captured pixel and arithmetic registers.
  logic [15:0] depth_r;
  logic [7:0]  blue_r, green_r, red_r;
  logic [15:0] mdx_r, mdy_r;
  logic        negx_r, negy_r;
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] prod_r;
  logic [31:0] zfull_r;
  logic [23:0] t_r;
  logic [47:0] a_r;
  logic [31:0] x_r;
  logic [48:0] comb_lo;
  logic [44:0] comb_mag;
  logic        comb_neg;
  logic [31:0] comb_sat;
  out_t        out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= RST_IMAGE_WIDTH;
      sample_interval_r <= RST_SAMPLE_INTERVAL;
      depth_limit_r     <= RST_DEPTH_LIMIT;
      center_x_r        <= RST_CENTER_X;
      center_y_r        <= RST_CENTER_Y;
      inv_focal_x_r     <= RST_INV_FOCAL_X;
      inv_focal_y_r     <= RST_INV_FOCAL_Y;
      inv_depth_scale_r <= RST_INV_DEPTH_SCALE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata[12:0];
        REG_SAMPLE_INTERVAL: sample_interval_r <= cfg_wdata[7:0];
        REG_DEPTH_LIMIT:     depth_limit_r     <= cfg_wdata[15:0];
        REG_CENTER_X:        center_x_r        <= cfg_wdata[15:0];
        REG_CENTER_Y:        center_y_r        <= cfg_wdata[15:0];
        REG_INV_FOCAL_X:     inv_focal_x_r     <= cfg_wdata[23:0];
        REG_INV_FOCAL_Y:     inv_focal_y_r     <= cfg_wdata[23:0];
        REG_INV_DEPTH_SCALE: inv_depth_scale_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // A frame start puts the current pixel at the origin.
  assign col_cur = in_data.frame_start ? 12'd0 : col_r;
  assign row_cur = in_data.frame_start ? 12'd0 : row_r;
  assign cph_cur = in_data.frame_start ? 8'd0  : cph_r;
  assign rph_cur = in_data.frame_start ? 8'd0  : rph_r;

  assign width_eff = (image_width_r == 13'd0) ? 13'd1 :
                     (image_width_r > MAX_WIDTH) ? MAX_WIDTH : image_width_r;
  assign interval_eff = (sample_interval_r == 8'd0) ? 8'd1 : sample_interval_r;

  assign col_inc = {1'b0, col_cur} + 13'd1;
  assign row_inc = {1'b0, row_cur} + 13'd1;
  assign cph_inc = {1'b0, cph_cur} + 9'd1;
  assign rph_inc = {1'b0, rph_cur} + 9'd1;

  always_comb begin
    col_nxt = col_inc[11:0];
    cph_nxt = (cph_inc >= {1'b0, interval_eff}) ? 8'd0 : cph_inc[7:0];
    row_nxt = row_cur;
    rph_nxt = rph_cur;
    if (col_inc >= width_eff) begin
      col_nxt = 12'd0;
      cph_nxt = 8'd0;
      if (row_inc >= MAX_HEIGHT) begin
        row_nxt = 12'd0;
        rph_nxt = 8'd0;
      end else begin
        row_nxt = row_inc[11:0];
        rph_nxt = (rph_inc >= {1'b0, interval_eff}) ? 8'd0 : rph_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 12'd0;
      row_r <= 12'd0;
      cph_r <= 8'd0;
      rph_r <= 8'd0;
    end else if (cmd.accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
    end
  end

  assign sts.kept = (cph_cur == 8'd0) && (rph_cur == 8'd0) &&
                    (in_data.depth_raw != 16'd0) && (in_data.depth_raw < depth_limit_r);

  // Signed Q12.4 offsets from the principal point, kept as sign and magnitude.
  assign pos_x = {col_cur, 4'b0000};
  assign pos_y = {row_cur, 4'b0000};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_r <= in_data.depth_raw;
      blue_r  <= in_data.blue;
      green_r <= in_data.green;
      red_r   <= in_data.red;
      negx_r  <= center_x_r > pos_x;
      mdx_r   <= (center_x_r > pos_x) ? center_x_r - pos_x : pos_x - center_x_r;
      negy_r  <= center_y_r > pos_y;
      mdy_r   <= (center_y_r > pos_y) ? center_y_r - pos_y : pos_y - center_y_r;
    end
  end

  // Shared multiplier; every product here stays below 2^48.
  always_comb begin
    case (cmd.mul_sel)
      MS_Z: begin
        mul_a = {8'd0, depth_r};
        mul_b = inv_depth_scale_r;
      end
      MS_TX: begin
        mul_a = {8'd0, mdx_r};
        mul_b = prod_r[47:16];
      end
      MS_AX: begin
        mul_a = prod_r[47:24];
        mul_b = {8'd0, inv_focal_x_r};
      end
      MS_BX: begin
        mul_a = t_r;
        mul_b = {8'd0, inv_focal_x_r};
      end
      MS_TY: begin
        mul_a = {8'd0, mdy_r};
        mul_b = zfull_r;
      end
      MS_AY: begin
        mul_a = prod_r[47:24];
        mul_b = {8'd0, inv_focal_y_r};
      end
      MS_BY: begin
        mul_a = t_r;
        mul_b = {8'd0, inv_focal_y_r};
      end
      default: begin
        mul_a = 24'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 48'({32'd0, mul_a} * {24'd0, mul_b});
    if (cmd.ld_z) zfull_r <= prod_r[47:16];
    if (cmd.ld_t) t_r <= prod_r[23:0];
    if (cmd.ld_a) a_r <= prod_r;
    if (cmd.ld_x) x_r <= comb_sat;
  end

  // (a * 2^24 + b) >> 28, then the sign and the 32-bit saturation.
  assign comb_lo  = {21'd0, a_r[3:0], 24'd0} + {1'b0, prod_r};
  assign comb_mag = {1'b0, a_r[47:4]} + {24'd0, comb_lo[48:28]};
  assign comb_neg = cmd.ld_x ? negx_r : negy_r;

  always_comb begin
    if (!comb_neg) begin
      comb_sat = (|comb_mag[44:31]) ? 32'h7FFF_FFFF : {1'b0, comb_mag[30:0]};
    end else begin
      comb_sat = (|comb_mag[44:31]) ? 32'h8000_0000 : 32'd0 - {1'b0, comb_mag[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_r.point_x   <= x_r;
      out_r.point_y   <= comb_sat;
      out_r.point_z   <= zfull_r[31] ? 31'h7FFF_FFFF : zfull_r[30:0];
      out_r.out_blue  <= blue_r;
      out_r.out_green <= green_r;
      out_r.out_red   <= red_r;
    end
  end

  assign out_data = out_r;

endmodule

[hw/rtl/dtpc_ctrl.sv]
`timescale 1ns / 1ps

module dtpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dtpc_pkg::sts_t  sts,
  output dtpc_pkg::cmd_t  cmd
);
  import dtpc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MZ   = 4'd1;
  localparam logic [3:0] S_TX   = 4'd2;
  localparam logic [3:0] S_AX   = 4'd3;
  localparam logic [3:0] S_BX   = 4'd4;
  localparam logic [3:0] S_TY   = 4'd5;
  localparam logic [3:0] S_AY   = 4'd6;
  localparam logic [3:0] S_BY   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.mul_sel   = MS_Z;
    case (state_r)
      S_IDLE: begin
        if (accept && sts.kept) state_nxt = S_MZ;
      end
      S_MZ: begin
        cmd.mul_sel = MS_Z;
        state_nxt   = S_TX;
      end
      S_TX: begin
        cmd.mul_sel = MS_TX;
        cmd.ld_z    = 1'b1;
        state_nxt   = S_AX;
      end
      S_AX: begin
        cmd.mul_sel = MS_AX;
        cmd.ld_t    = 1'b1;
        state_nxt   = S_BX;
      end
      S_BX: begin
        cmd.mul_sel = MS_BX;
        cmd.ld_a    = 1'b1;
        state_nxt   = S_TY;
      end
      S_TY: begin
        cmd.mul_sel = MS_TY;
        cmd.ld_x    = 1'b1;
        state_nxt   = S_AY;
      end
      S_AY: begin
        cmd.mul_sel = MS_AY;
        cmd.ld_t    = 1'b1;
        state_nxt   = S_BY;
      end
      S_BY: begin
        cmd.mul_sel = MS_BY;
        cmd.ld_a    = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // The last product is recomputed each cycle so y stays put while the output waits.
        cmd.mul_sel = MS_BY;
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_kept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.kept) |=> (state_r == S_MZ))
    else $error("kept request did not start the multiply sequence");

  a_seq_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MZ) |-> ##7 (state_r == S_DONE))
    else $error("multiply sequence did not reach the final step in time");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the final step");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (state_r == S_IDLE && out_valid_r))
    else $error("final step stalled with a free output register");

endmodule

[hw/rtl/depth_to_point_cloud.sv]
`timescale 1ns / 1ps
// A kept pixel's point is offered on out_valid once the controller's S_DONE loads the output register.
// A dropped pixel leaves in_ready high for the next pixel; a kept pixel holds the input
// through the seven products that share one multiplier, plus a wait while the output is full.
// Reset (rst_n, synchronous, active low) loads the register defaults, zeroes the raster
// position and empties the output register.

module depth_to_point_cloud (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dtpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dtpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dtpc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dtpc_pkg::out_t                    out_data
);
  import dtpc_pkg::*;

  // The controller steps through the multiply sequence and owns both handshakes.
  // The datapath holds the registers, the raster position, the shared multiplier
  // and the output register. Only commands and the keep decision pass between them.
  cmd_t cmd;
  sts_t sts;

  dtpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Every accepted request advances the raster position, kept or not. A kept
  // pixel computes z first, then x and y, each as (offset * z) times the focal
  // reciprocal, split into two 24-bit halves so no product exceeds 48 bits.
  dtpc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
